// ===== hdl/srcs_pkg.sv =====
`timescale 1ns / 1ps

package srcs_pkg;

    localparam int LAST_SLOT   = 100;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_W      = 7;
    localparam int TICK_W      = 8;
    localparam int DATA_W      = 16;
    localparam int PHASE_W     = 3;

    localparam logic [SAMPLE_BITS-1:0] MARKER_VALUE = SAMPLE_BITS'(1000);

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_RESET  = 3'd1,
        PH_ENABLE = 3'd2,
        PH_SAMPLE = 3'd3,
        PH_AWAIT  = 3'd4
    } phase_t;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef struct packed {
        logic converter_reset;
        logic converter_enable;
        logic converter_disable;
        logic send_request;
        logic run_stop;
    } pulse_t;

endpackage

// ===== hdl/srcs_ram.sv =====
`timescale 1ns / 1ps

module srcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/step_response_capture_sequencer.sv =====
`timescale 1ns / 1ps

// Step response capture sequencer.
// Each request on the s_ channel is either a millisecond tick or a read of a
// stored sample (selected by s_tuser). A tick advances the sequence: idle,
// converter reset pulse, converter enable pulse, sampling, await acknowledge.
// While sampling, every sample_period ticks the speed is stored at the next
// slot; slot 0 reads as the 1000 marker once a capture has stored anything,
// and the last slot mirrors the sample taken on the same tick as the one
// before it. A read returns the stored sample without touching the sequence.
// Every request gives exactly one result on the m_ channel, through two registered
// stages: the sample memory read, then the output register.
// One request is taken per cycle as long as the receiver keeps up; when
// m_tready is low the results back up through the two stages and s_tready
// falls once both are full. Reset clears the sequence, the period register
// and the per-slot valid flags, so every slot reads as zero until written;
// it takes effect at once, with no clearing pass.
module step_response_capture_sequencer
    import srcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,    // sample_period
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // start_valid, sent_ack, speed_sample[16], read_index[7]
    input  logic        s_tuser,        // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // converter_reset, converter_enable, converter_disable,
                                        // send_request, run_stop, phase_now[3], read_data[16]
);

    logic [TICK_W-1:0]    sample_period_reg;
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic [SLOT_W-1:0]    sample_slot_reg, sample_slot_next;
    logic [LAST_SLOT-1:0] slot_valid_reg, slot_valid_next;

    logic                 s1_valid_reg;
    pulse_t               s1_pulse_reg;
    phase_t               s1_phase_reg;
    logic                 s1_read_reg;
    logic                 s1_marker_reg;
    logic                 s1_rd_ok_reg;

    logic                 m_valid_reg;
    logic [23:0]          m_tdata_reg;

    logic                 start_valid;
    logic                 sent_ack;
    logic [DATA_W-1:0]    speed_sample;
    logic [SLOT_W-1:0]    read_index;
    func_t                func;

    logic                 in_accept;
    logic                 tick;
    logic                 adv_out;
    logic [TICK_W-1:0]    tick_inc;
    logic                 hit;
    logic                 last_hit;
    pulse_t               pulse;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                 rd_ok;
    logic [DATA_W-1:0]    read_data;

    assign start_valid  = s_tdata[0];
    assign sent_ack     = s_tdata[1];
    assign speed_sample = s_tdata[17:2];
    assign read_index   = s_tdata[24:18];
    assign func         = func_t'(s_tuser);

    assign adv_out   = !m_valid_reg || m_tready;
    assign s_tready  = adv_out || !s1_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign tick      = in_accept && (func == FUNC_TICK);

    assign tick_inc = tick_count_reg + TICK_W'(1);
    assign hit      = (phase_reg == PH_SAMPLE) && (tick_inc == sample_period_reg);
    assign last_hit = hit && (sample_slot_reg == SLOT_W'(LAST_SLOT - 1));

    // Next state of the sequence.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (start_valid) begin
                    phase_next = PH_RESET;
                end
            end
            PH_RESET:  phase_next = PH_ENABLE;
            PH_ENABLE: phase_next = PH_SAMPLE;
            PH_SAMPLE: begin
                if (last_hit) begin
                    phase_next = PH_AWAIT;
                end
            end
            PH_AWAIT: begin
                if (sent_ack) begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Pulses raised by a tick in the current phase.
    always_comb begin
        pulse = '0;
        case (phase_reg)
            PH_RESET:  pulse.converter_reset  = 1'b1;
            PH_ENABLE: pulse.converter_enable = 1'b1;
            PH_SAMPLE: begin
                pulse.send_request = last_hit;
                pulse.run_stop     = last_hit;
            end
            PH_AWAIT:  pulse.converter_disable = sent_ack;
            default:   pulse = '0;
        endcase
    end

    // Counters and valid flags. Bit 0 of the valid flags marks the marker slot.
    always_comb begin
        tick_count_next  = tick_count_reg;
        sample_slot_next = sample_slot_reg;
        slot_valid_next  = slot_valid_reg;
        if (phase_reg == PH_SAMPLE) begin
            tick_count_next = tick_inc;
            if (hit) begin
                tick_count_next                  = '0;
                slot_valid_next[0]               = 1'b1;
                slot_valid_next[sample_slot_reg] = 1'b1;
                sample_slot_next = last_hit ? SLOT_W'(1) : sample_slot_reg + SLOT_W'(1);
            end
        end
    end

    assign ram_we = tick && hit;

    // The last slot reads the same value as the slot before it; indexes beyond it read as zero.
    always_comb begin
        ram_raddr = read_index;
        rd_ok     = 1'b0;
        if (read_index == SLOT_W'(LAST_SLOT)) begin
            ram_raddr = SLOT_W'(LAST_SLOT - 1);
            rd_ok     = slot_valid_reg[LAST_SLOT-1];
        end else if (read_index < SLOT_W'(LAST_SLOT)) begin
            rd_ok = slot_valid_reg[read_index];
        end
    end

    srcs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LAST_SLOT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (sample_slot_reg),
        .wdata (SAMPLE_BITS'(speed_sample)),
        .re    (in_accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_period_reg <= '0;
            phase_reg         <= PH_IDLE;
            tick_count_reg    <= '0;
            sample_slot_reg   <= SLOT_W'(1);
            slot_valid_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                sample_period_reg <= cfg_wr_data;
            end
            if (tick) begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                sample_slot_reg <= sample_slot_next;
                slot_valid_reg  <= slot_valid_next;
            end
        end
    end

    // Stage 1 waits for the memory read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pulse_reg  <= tick ? pulse : '0;
            s1_phase_reg  <= tick ? phase_next : phase_reg;
            s1_read_reg   <= (func == FUNC_READ);
            s1_marker_reg <= (read_index == '0);
            s1_rd_ok_reg  <= rd_ok;
        end
    end

    always_comb begin
        read_data = '0;
        if (s1_read_reg && s1_rd_ok_reg) begin
            read_data = s1_marker_reg ? MARKER_VALUE[DATA_W-1:0] : ram_rdata[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv_out) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && s1_valid_reg) begin
            m_tdata_reg <= {read_data, s1_phase_reg,
                            s1_pulse_reg.run_stop, s1_pulse_reg.send_request,
                            s1_pulse_reg.converter_disable, s1_pulse_reg.converter_enable,
                            s1_pulse_reg.converter_reset};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
